[rtl/tlca_pkg.sv]
package tlca_pkg;

  localparam int NODE_W  = 10;
  localparam int POS_W   = 11;
  localparam int DEPTH_W = 10;
  localparam int DIST_W  = 11;
  localparam int TYPE_W  = 2;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_TOUR_DEF  = 2048;

  localparam logic [TYPE_W-1:0] REQ_TOUR_WR = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_NODE_WR = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_QUERY   = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } rmq_stat_t;

endpackage

[rtl/tlca_req_if.sv]
interface tlca_req_if;
  logic                            valid;
  logic                            ready;
  logic [tlca_pkg::TYPE_W-1:0]     req_type;
  logic [tlca_pkg::POS_W-1:0]      tour_pos;
  logic [tlca_pkg::NODE_W-1:0]     tour_node_id;
  logic [tlca_pkg::DEPTH_W-1:0]    tour_depth;
  logic [tlca_pkg::NODE_W-1:0]     node_id;
  logic [tlca_pkg::POS_W-1:0]      node_first_pos;
  logic [tlca_pkg::DEPTH_W-1:0]    node_depth_value;
  logic [tlca_pkg::NODE_W-1:0]     query_u;
  logic [tlca_pkg::NODE_W-1:0]     query_v;
  logic [tlca_pkg::NODE_W-1:0]     query_root;

  modport source (
    output valid, req_type, tour_pos, tour_node_id, tour_depth, node_id,
           node_first_pos, node_depth_value, query_u, query_v, query_root,
    input  ready
  );
  modport sink (
    input  valid, req_type, tour_pos, tour_node_id, tour_depth, node_id,
           node_first_pos, node_depth_value, query_u, query_v, query_root,
    output ready
  );
endinterface

[rtl/tlca_rsp_if.sv]
interface tlca_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tlca_pkg::NODE_W-1:0]  rerooted_ancestor;
  logic [tlca_pkg::NODE_W-1:0]  rooted_ancestor;
  logic [tlca_pkg::DIST_W-1:0]  edge_distance;

  modport source (
    output valid, rerooted_ancestor, rooted_ancestor, edge_distance,
    input  ready
  );
  modport sink (
    input  valid, rerooted_ancestor, rooted_ancestor, edge_distance,
    output ready
  );
endinterface

[rtl/tlca_ram.sv]
module tlca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tlca_rmq.sv]
// Tour stores plus a linear range-minimum scanner: one entry per cycle,
// one depth compare shared by every scan.
module tlca_rmq #(
  parameter int MAX_TOUR = tlca_pkg::MAX_TOUR_DEF,
  localparam int TOUR_AW = $clog2(MAX_TOUR)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [TOUR_AW-1:0]           wr_addr,
  input  logic [tlca_pkg::NODE_W-1:0]  wr_node,
  input  logic [tlca_pkg::DEPTH_W-1:0] wr_depth,
  input  logic                         start,
  input  logic [TOUR_AW-1:0]           pos_a,
  input  logic [TOUR_AW-1:0]           pos_b,
  output tlca_pkg::rmq_stat_t          stat,
  output logic [tlca_pkg::NODE_W-1:0]  min_node
);

  logic                         run;
  logic                         rd_v;
  logic                         rd_last;
  logic                         rd_first;
  logic                         done;
  logic [TOUR_AW-1:0]           addr;
  logic [TOUR_AW-1:0]           hi;
  logic [tlca_pkg::NODE_W-1:0]  q_node;
  logic [tlca_pkg::DEPTH_W-1:0] q_depth;
  logic [tlca_pkg::DEPTH_W-1:0] best_depth;

  tlca_ram #(.WIDTH(tlca_pkg::NODE_W), .DEPTH(MAX_TOUR)) u_node_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_node),
    .re    (run),
    .raddr (addr),
    .rdata (q_node)
  );

  tlca_ram #(.WIDTH(tlca_pkg::DEPTH_W), .DEPTH(MAX_TOUR)) u_depth_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_depth),
    .re    (run),
    .raddr (addr),
    .rdata (q_depth)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      rd_v     <= 1'b0;
      rd_last  <= 1'b0;
      rd_first <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= rd_v && rd_last;
      rd_v <= run;
      if (start) begin
        run      <= 1'b1;
        rd_first <= 1'b1;
        addr     <= (pos_a <= pos_b) ? pos_a : pos_b;
        hi       <= (pos_a <= pos_b) ? pos_b : pos_a;
      end else if (run) begin
        rd_last <= (addr == hi);
        if (addr == hi) begin
          run <= 1'b0;
        end else begin
          addr <= addr + TOUR_AW'(1);
        end
      end
      // strict less-than keeps the leftmost minimum
      if (rd_v) begin
        rd_first <= 1'b0;
        if (rd_first || (q_depth < best_depth)) begin
          best_depth <= q_depth;
          min_node   <= q_node;
        end
      end
    end
  end

  assign stat.busy = run | rd_v;
  assign stat.done = done;

endmodule

[rtl/tree_lca_euler_rmq.sv]
// Write beats are accepted whenever ready is high; ready stays high between queries.
// A query runs one tour scan when query_root equals main_root, else three;
// the scans share the single tour depth compare and so run one after another.
// One query at a time; ready is low from its acceptance to its result.
// rst is synchronous, active high: clears control and main_root, not stores.
module tree_lca_euler_rmq #(
  parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEF,
  parameter int MAX_TOUR  = tlca_pkg::MAX_TOUR_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tlca_pkg::NODE_W-1:0] cfg_wdata,
  tlca_req_if.sink                    req,
  tlca_rsp_if.source                  rsp
);

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int TOUR_AW = $clog2(MAX_TOUR);

  // Sequencer: three node-store reads, up to three range scans, one depth
  // read for the rooted ancestor, then the result register is loaded.
  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_RD_U    = 12'b0000_0000_0010,
    ST_RD_V    = 12'b0000_0000_0100,
    ST_RD_R    = 12'b0000_0000_1000,
    ST_S1_GO   = 12'b0000_0001_0000,
    ST_S1_WAIT = 12'b0000_0010_0000,
    ST_S2_GO   = 12'b0000_0100_0000,
    ST_S2_WAIT = 12'b0000_1000_0000,
    ST_S3_GO   = 12'b0001_0000_0000,
    ST_S3_WAIT = 12'b0010_0000_0000,
    ST_DEP_RD  = 12'b0100_0000_0000,
    ST_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [tlca_pkg::NODE_W-1:0]  main_root;
  logic [tlca_pkg::NODE_W-1:0]  qu, qv, qr;
  logic [TOUR_AW-1:0]           pu, pv, pr;
  logic [tlca_pkg::DEPTH_W-1:0] du, dv;
  logic [tlca_pkg::NODE_W-1:0]  c1, c2, c3;

  logic                         rsp_valid;
  logic [tlca_pkg::NODE_W-1:0]  rsp_rer;
  logic [tlca_pkg::NODE_W-1:0]  rsp_root;
  logic [tlca_pkg::DIST_W-1:0]  rsp_dist;

  logic                         req_beat;
  logic                         tour_we;
  logic                         node_we;

  // node store read side
  logic                         nd_re;
  logic [tlca_pkg::NODE_W-1:0]  nd_node;
  logic                         nd_ok;
  logic [tlca_pkg::POS_W-1:0]   fp_q;
  logic [tlca_pkg::DEPTH_W-1:0] dep_q;
  logic [tlca_pkg::POS_W-1:0]   fp_raw;
  logic [TOUR_AW-1:0]           fp_sat;
  logic [tlca_pkg::DEPTH_W-1:0] dep_raw;

  // scanner handshake
  logic                         rmq_start;
  logic [TOUR_AW-1:0]           rmq_a, rmq_b;
  tlca_pkg::rmq_stat_t          rmq_stat;
  logic [tlca_pkg::NODE_W-1:0]  rmq_node;

  // result math
  logic [tlca_pkg::NODE_W-1:0]  rer;
  logic [tlca_pkg::DIST_W:0]    sum_uv;
  logic [tlca_pkg::DIST_W:0]    dbl_c;
  logic [tlca_pkg::DIST_W:0]    diff;
  logic [tlca_pkg::DIST_W-1:0]  dist_sat;
  logic                         rsp_load;

  assign req.ready = (state == ST_IDLE);
  assign req_beat  = req.valid && req.ready;

  // writes beyond the store depth are dropped
  assign tour_we = req_beat && (req.req_type == tlca_pkg::REQ_TOUR_WR)
                   && (32'(req.tour_pos) < MAX_TOUR);
  assign node_we = req_beat && (req.req_type == tlca_pkg::REQ_NODE_WR)
                   && (32'(req.node_id) < MAX_NODES);

  always_ff @(posedge clk) begin
    if (rst) begin
      main_root <= '0;
    end else if (cfg_we) begin
      main_root <= cfg_wdata;
    end
  end

  // ---- node stores: first tour position and depth per node ----
  always_comb begin
    case (state)
      ST_RD_U:   nd_node = qu;
      ST_RD_V:   nd_node = qv;
      ST_RD_R:   nd_node = qr;
      ST_DEP_RD: nd_node = c1;
      default:   nd_node = qu;
    endcase
  end

  assign nd_re = (state == ST_RD_U) || (state == ST_RD_V) ||
                 (state == ST_RD_R) || (state == ST_DEP_RD);

  tlca_ram #(.WIDTH(tlca_pkg::POS_W), .DEPTH(MAX_NODES)) u_first_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (NODE_AW'(req.node_id)),
    .wdata (req.node_first_pos),
    .re    (nd_re),
    .raddr (NODE_AW'(nd_node)),
    .rdata (fp_q)
  );

  tlca_ram #(.WIDTH(tlca_pkg::DEPTH_W), .DEPTH(MAX_NODES)) u_ndep_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (NODE_AW'(req.node_id)),
    .wdata (req.node_depth_value),
    .re    (nd_re),
    .raddr (NODE_AW'(nd_node)),
    .rdata (dep_q)
  );

  // out-of-range node ids read as zero; flag travels with the read data
  always_ff @(posedge clk) begin
    if (nd_re) begin
      nd_ok <= (32'(nd_node) < MAX_NODES);
    end
  end

  assign fp_raw  = nd_ok ? fp_q : '0;
  assign dep_raw = nd_ok ? dep_q : '0;
  // a stored position past the tour end clamps to the last entry
  assign fp_sat  = (32'(fp_raw) >= MAX_TOUR) ? TOUR_AW'(MAX_TOUR - 1)
                                             : TOUR_AW'(fp_raw);

  // ---- range-minimum scanner ----
  assign rmq_start = (state == ST_S1_GO) || (state == ST_S2_GO) ||
                     (state == ST_S3_GO);

  always_comb begin
    case (state)
      ST_S2_GO: begin
        rmq_a = pu;
        rmq_b = pr;
      end
      ST_S3_GO: begin
        rmq_a = pv;
        rmq_b = pr;
      end
      default: begin
        rmq_a = pu;
        rmq_b = pv;
      end
    endcase
  end

  tlca_rmq #(.MAX_TOUR(MAX_TOUR)) u_rmq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (tour_we),
    .wr_addr  (TOUR_AW'(req.tour_pos)),
    .wr_node  (req.tour_node_id),
    .wr_depth (req.tour_depth),
    .start    (rmq_start),
    .pos_a    (rmq_a),
    .pos_b    (rmq_b),
    .stat     (rmq_stat),
    .min_node (rmq_node)
  );

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_beat && (req.req_type == tlca_pkg::REQ_QUERY)) begin
          state_next = ST_RD_U;
        end
      end
      ST_RD_U:  state_next = ST_RD_V;
      ST_RD_V:  state_next = ST_RD_R;
      ST_RD_R:  state_next = ST_S1_GO;
      ST_S1_GO: state_next = ST_S1_WAIT;
      ST_S1_WAIT: begin
        if (rmq_stat.done) begin
          // same root: the rerooted answer is the rooted one
          state_next = (qr == main_root) ? ST_DEP_RD : ST_S2_GO;
        end
      end
      ST_S2_GO: state_next = ST_S2_WAIT;
      ST_S2_WAIT: begin
        if (rmq_stat.done) begin
          state_next = ST_S3_GO;
        end
      end
      ST_S3_GO: state_next = ST_S3_WAIT;
      ST_S3_WAIT: begin
        if (rmq_stat.done) begin
          state_next = ST_DEP_RD;
        end
      end
      ST_DEP_RD: state_next = ST_DONE;
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // data path captures: query operands on the request beat, the rest keyed by state
  always_ff @(posedge clk) begin
    if (req_beat) begin
      qu <= req.query_u;
      qv <= req.query_v;
      qr <= req.query_root;
    end
    case (state)
      ST_RD_V: begin
        pu <= fp_sat;
        du <= dep_raw;
      end
      ST_RD_R: begin
        pv <= fp_sat;
        dv <= dep_raw;
      end
      ST_S1_GO: pr <= fp_sat;
      ST_S1_WAIT: begin
        if (rmq_stat.done) begin
          c1 <= rmq_node;
        end
      end
      ST_S2_WAIT: begin
        if (rmq_stat.done) begin
          c2 <= rmq_node;
        end
      end
      ST_S3_WAIT: begin
        if (rmq_stat.done) begin
          c3 <= rmq_node;
        end
      end
      default: begin
      end
    endcase
  end

  // ---- result: c1 when the roots match, else odd one out of the three answers, and edge distance ----
  always_comb begin
    if (qr == main_root) begin
      rer = c1;
    end else if (c1 == c2) begin
      rer = c3;
    end else if (c1 == c3) begin
      rer = c2;
    end else begin
      rer = c1;
    end
  end

  // du + dv - 2 * depth(c1), floored at zero; the top never exceeds 2046
  assign sum_uv   = (tlca_pkg::DIST_W + 1)'(du) + (tlca_pkg::DIST_W + 1)'(dv);
  assign dbl_c    = {1'b0, dep_raw, 1'b0};
  assign diff     = sum_uv - dbl_c;
  assign dist_sat = (sum_uv < dbl_c) ? '0 : diff[tlca_pkg::DIST_W-1:0];

  // output register decouples the sink; new beat loads when the old one has gone or leaves in that cycle
  assign rsp_load = (state == ST_DONE) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_rer  <= rer;
      rsp_root <= c1;
      rsp_dist <= dist_sat;
    end
  end

  assign rsp.valid             = rsp_valid;
  assign rsp.rerooted_ancestor = rsp_rer;
  assign rsp.rooted_ancestor   = rsp_root;
  assign rsp.edge_distance     = rsp_dist;

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    rmq_start |-> !rmq_stat.busy)
    else $error("scan started while scanner busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rmq_stat.done |-> (state == ST_S1_WAIT || state == ST_S2_WAIT ||
                       state == ST_S3_WAIT))
    else $error("scan finished outside a wait state");

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (req_beat && req.req_type == tlca_pkg::REQ_QUERY) |=> !req.ready)
    else $error("ready high right after a query beat");
`endif

endmodule
